@@ sv/lsss_pkg.sv @@
// ----------------------------------------------------------------------------
// lsss_pkg: shared definitions for the list store search statistics unit
// Store depth, derived widths, field widths and command codes.
// ----------------------------------------------------------------------------
package lsss_pkg;

   // Number of entries the store can hold.
   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DATA_W  = 32;

   // Fixed widths of the result fields.
   localparam int POS_W   = 6;
   localparam int CNT_W   = 7;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [ADDR_W:0]          count_type;

endpackage

@@ sv/lsss_ram.sv @@
// ----------------------------------------------------------------------------
// lsss_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsss_ram #(
   parameter int DEPTH_P = 64,
   parameter int WIDTH_P = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  logic [WIDTH_P-1:0]         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic [WIDTH_P-1:0]         rd_data
);

   logic [WIDTH_P-1:0] mem_ff [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/list_store_search_stats_unit.sv @@
// Insert, clear and unused commands go straight to S_DONE, which registers the result beat.
// A find reads the held entries from position 0, one per cycle, until a match or the last entry.
// That rate is set by the single read port of the entry RAM and the shared equality compare.
// One command in flight: req_tready is high only in S_IDLE, so a beat waits for the last result.
// Reset is synchronous and active high; it empties the store and zeroes every statistic.
// The entry RAM is not cleared: only positions below the entry count are ever read.
// ----------------------------------------------------------------------------
// list_store_search_stats_unit: bounded front-insert store with linear search
// Keeps up to DEPTH signed values, newest at position 0, and reports the
// count, wrapping sum and frontmost extremes with every result beat.
// ----------------------------------------------------------------------------
module list_store_search_stats_unit
   import lsss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Command channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [31:0] value
   input  logic [1:0]         req_tuser,   // [1:0] command
   // Result channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [0] found, [6:1] found_position, [13:7] entry_count, [45:14] total,
   // [77:46] max_value, [83:78] max_position, [115:84] min_value,
   // [121:116] min_position, [122] empty_flag, [123] insert_refused,
   // [127:124] zero
   output logic [127:0]       rsp_tdata
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_DONE   = 2'd2;

   // The store is kept as a ring in the RAM. Logical position i lives at
   // physical address head + i (modulo DEPTH), so an insert only has to move
   // the head back by one and write a single word; nothing is shifted.
   logic [1:0] state_ff,     state_in;
   addr_type   head_ff,      head_in;
   count_type  count_ff,     count_in;
   data_type   sum_ff,       sum_in;
   data_type   max_ff,       max_in;
   addr_type   max_pos_ff,   max_pos_in;
   data_type   min_ff,       min_in;
   addr_type   min_pos_ff,   min_pos_in;

   // Per-command working registers.
   data_type   key_ff,       key_in;
   logic       found_ff,     found_in;
   addr_type   found_pos_ff, found_pos_in;
   logic       refused_ff,   refused_in;

   // Search walk: issue_idx is the next position to read, rd_valid and
   // rd_pos describe the word that the RAM presents in this cycle.
   count_type  issue_idx_ff, issue_idx_in;
   logic       rd_valid_ff,  rd_valid_in;
   addr_type   rd_pos_ff,    rd_pos_in;

   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [127:0] rsp_tdata_ff,  rsp_tdata_in;

   logic         accept;
   logic         ram_wr_en;
   addr_type     ram_wr_addr;
   logic         ram_rd_en;
   addr_type     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   logic [ADDR_W:0]   rd_addr_raw;
   data_type     req_value;
   logic         hit;
   addr_type     head_dec;

   assign req_value  = data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign head_dec   = (head_ff == '0) ? addr_type'(DEPTH - 1) : head_ff - 1'b1;

   // Physical read address for the position being issued, with ring wrap.
   assign rd_addr_raw = {1'b0, head_ff} + (ADDR_W+1)'(issue_idx_ff);
   assign ram_rd_addr = (rd_addr_raw >= (ADDR_W+1)'(DEPTH)) ?
                        addr_type'(rd_addr_raw - (ADDR_W+1)'(DEPTH)) :
                        addr_type'(rd_addr_raw);

   // The shared compare unit: one stored entry against the search key.
   assign hit = rd_valid_ff && (data_type'(ram_rd_data) == key_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      max_in        = max_ff;
      max_pos_in    = max_pos_ff;
      min_in        = min_ff;
      min_pos_in    = min_pos_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      found_pos_in  = found_pos_ff;
      refused_in    = refused_ff;
      issue_idx_in  = issue_idx_ff;
      rd_valid_in   = 1'b0;
      rd_pos_in     = rd_pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head_dec;
      ram_rd_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in       = req_value;
               found_in     = 1'b0;
               found_pos_in = '0;
               refused_in   = 1'b0;
               issue_idx_in = '0;
               state_in     = S_DONE;
               case (req_tuser)
                  CMD_INSERT: begin
                     if (count_ff >= count_type'(DEPTH)) begin
                        refused_in = 1'b1;
                     end else begin
                        // New value goes in front of the current head.
                        ram_wr_en = 1'b1;
                        head_in   = head_dec;
                        count_in  = count_ff + 1'b1;
                        sum_in    = sum_ff + req_value;
                        if (count_ff == '0) begin
                           max_in     = req_value;
                           max_pos_in = '0;
                           min_in     = req_value;
                           min_pos_in = '0;
                        end else begin
                           // Ties go to the front, so an equal value takes position 0.
                           if (req_value >= max_ff) begin
                              max_in     = req_value;
                              max_pos_in = '0;
                           end else begin
                              max_pos_in = max_pos_ff + 1'b1;
                           end
                           if (req_value <= min_ff) begin
                              min_in     = req_value;
                              min_pos_in = '0;
                           end else begin
                              min_pos_in = min_pos_ff + 1'b1;
                           end
                        end
                     end
                  end
                  CMD_FIND: begin
                     state_in = S_SEARCH;
                  end
                  CMD_CLEAR: begin
                     count_in   = '0;
                     sum_in     = '0;
                     max_in     = '0;
                     max_pos_in = '0;
                     min_in     = '0;
                     min_pos_in = '0;
                  end
                  default: begin
                     // Unused command code: the result simply reports the state.
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               found_in     = 1'b1;
               found_pos_in = rd_pos_ff;
               state_in     = S_DONE;
            end else if (issue_idx_ff == count_ff && !rd_valid_ff) begin
               state_in = S_DONE;
            end else if (issue_idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               rd_valid_in  = 1'b1;
               rd_pos_in    = addr_type'(issue_idx_ff);
               issue_idx_in = issue_idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            // Load the output register once the previous beat has gone.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0,
                                refused_ff,
                                (count_ff == '0),
                                POS_W'(min_pos_ff),
                                min_ff,
                                POS_W'(max_pos_ff),
                                max_ff,
                                sum_ff,
                                CNT_W'(count_ff),
                                POS_W'(found_pos_ff),
                                found_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         max_ff        <= '0;
         max_pos_ff    <= '0;
         min_ff        <= '0;
         min_pos_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         max_ff        <= max_in;
         max_pos_ff    <= max_pos_in;
         min_ff        <= min_in;
         min_pos_ff    <= min_pos_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      key_ff       <= key_in;
      found_ff     <= found_in;
      found_pos_ff <= found_pos_in;
      refused_ff   <= refused_in;
      issue_idx_ff <= issue_idx_in;
      rd_pos_ff    <= rd_pos_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   lsss_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The store never holds more than DEPTH entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count above store depth");

   // An empty store carries no statistics.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0 && max_ff == '0 && min_ff == '0 &&
                            max_pos_ff == '0 && min_pos_ff == '0))
      else $error("statistics left over in an empty store");

   // Extreme positions always point inside the held entries.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ((count_type'(max_pos_ff) < count_ff) &&
                            (count_type'(min_pos_ff) < count_ff)))
      else $error("extreme position beyond entry count");

   // The search never issues past the held entries.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (issue_idx_ff <= count_ff))
      else $error("search walked past the held entries");

   // A reported match lies inside the held entries.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[0]) |->
         (rsp_tdata_ff[6:1] < rsp_tdata_ff[13:7]))
      else $error("match position beyond entry count");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for list_store_search_stats_unit
// Drives insert, find, clear and spare command beats under random sender
// bursts and receiver stalls, predicts every result beat with a model of the
// store kept in the bench, and compares each field of each result beat.
// ----------------------------------------------------------------------------
module testbench
   import lsss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The fourth command code has no meaning; the unit only reports its state.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1400;
   localparam int PRINT_BUDGET = 150;

   // One result beat, laid out as on rsp_tdata with found in bit 0.
   typedef struct packed {
      logic              insert_refused;
      logic              empty_flag;
      logic [POS_W-1:0]  min_position;
      data_type          min_value;
      logic [POS_W-1:0]  max_position;
      data_type          max_value;
      data_type          total;
      logic [CNT_W-1:0]  entry_count;
      logic [POS_W-1:0]  found_position;
      logic              found;
   } stats_beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;    // [31:0] value
   logic [1:0]    req_tuser = '0;    // [1:0] command
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // [0] found, [6:1] found_position, [13:7] entry_count, [45:14] total,
   // [77:46] max_value, [83:78] max_position, [115:84] min_value,
   // [121:116] min_position, [122] empty_flag, [123] insert_refused,
   // [127:124] zero
   logic [127:0]  rsp_tdata;

   list_store_search_stats_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the store and its running statistics. Only positions
   // below shadow_count are ever read, just as in the unit.
   data_type          shadow_store [DEPTH];
   int                shadow_count;
   data_type          shadow_sum;
   data_type          shadow_max;
   data_type          shadow_min;
   logic [POS_W-1:0]  shadow_max_pos;
   logic [POS_W-1:0]  shadow_min_pos;

   // Result beats predicted but not yet seen, oldest first.
   stats_beat_type    pending_stats [$];

   int error_count;
   int print_left = PRINT_BUDGET;
   int burst_left = 1;
   int long_hold_cycles;
   int beats_accepted, inserts_done, inserts_refused, finds_hit, finds_missed;
   int clears_done, spares_done, full_store_seen, hold_offs_done;

   // The clock runs at 100 MHz.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Empties the shadow store, as reset and the clear command do.
   function automatic void empty_shadow();
      shadow_count   = 0;
      shadow_sum     = '0;
      shadow_max     = '0;
      shadow_min     = '0;
      shadow_max_pos = '0;
      shadow_min_pos = '0;
   endfunction

   // Applies one accepted command to the shadow store and returns the result
   // beat that the unit must produce for it.
   function automatic stats_beat_type apply_command(input logic [CMD_W-1:0] cmd,
                                                    input data_type value);
      stats_beat_type beat;
      int i;
      beat = '0;
      case (cmd)
         CMD_INSERT: begin
            inserts_done++;
            if (shadow_count >= DEPTH) begin
               // A full store drops the value and changes nothing.
               beat.insert_refused = 1'b1;
               inserts_refused++;
            end else begin
               for (i = shadow_count; i > 0; i--)
                  shadow_store[i] = shadow_store[i-1];
               shadow_store[0] = value;
               if (shadow_count == 0) begin
                  shadow_max     = value;
                  shadow_min     = value;
                  shadow_max_pos = '0;
                  shadow_min_pos = '0;
               end else begin
                  // Ties go to the front, so an equal newcomer takes position 0.
                  if (value >= shadow_max) begin
                     shadow_max     = value;
                     shadow_max_pos = '0;
                  end else begin
                     shadow_max_pos++;
                  end
                  if (value <= shadow_min) begin
                     shadow_min     = value;
                     shadow_min_pos = '0;
                  end else begin
                     shadow_min_pos++;
                  end
               end
               shadow_count++;
               shadow_sum += value;
               if (shadow_count == DEPTH) full_store_seen++;
            end
         end
         CMD_FIND: begin
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_store[i] == value) begin
                  beat.found          = 1'b1;
                  beat.found_position = i[POS_W-1:0];
                  break;
               end
            end
            if (beat.found) finds_hit++;
            else finds_missed++;
         end
         CMD_CLEAR: begin
            empty_shadow();
            clears_done++;
         end
         default: begin
            spares_done++;
         end
      endcase
      beat.entry_count  = shadow_count[CNT_W-1:0];
      beat.total        = shadow_sum;
      beat.max_value    = shadow_max;
      beat.max_position = shadow_max_pos;
      beat.min_value    = shadow_min;
      beat.min_position = shadow_min_pos;
      beat.empty_flag   = (shadow_count == 0);
      return beat;
   endfunction

   // Sender idling: mostly short gaps, some long enough to land on any cycle
   // of a find walk.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 20);
      return $urandom_range(21, 80);
   endfunction

   // Burst lengths, with the odd long stretch of back-to-back offers.
   function automatic int pick_burst();
      if ($urandom_range(0, 9) == 0) return $urandom_range(40, 120);
      return $urandom_range(1, 24);
   endfunction

   // Style 0 spans the full range, style 1 a narrow band that makes repeated
   // values and tied extremes common, style 2 the corner values.
   function automatic data_type pick_value(input int style);
      case (style)
         0: return data_type'($urandom);
         1: return data_type'($signed($urandom_range(0, 16)) - 8);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   // A value that is held somewhere in the store, or a fresh one if empty.
   function automatic data_type pick_held_value(input int style);
      if (shadow_count == 0) return pick_value(style);
      return shadow_store[$urandom_range(0, shadow_count - 1)];
   endfunction

   // Offers one command beat, waits for the handshake, records the expected
   // result and then, at the end of a burst, idles for a random gap. Valid
   // stays high between beats of one burst.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input data_type value);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_stats.push_back(apply_command(cmd, value));
      beats_accepted++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
         burst_left = pick_burst();
      end
   endtask

   // Stops offering and waits until every predicted result beat has arrived.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   // One random step of a well-formed sequence: mostly inserts and finds,
   // finds split between held and arbitrary values.
   task automatic mixed_step(input int style);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)      send_command(CMD_INSERT, pick_value(style));
      else if (roll < 72) send_command(CMD_FIND, pick_held_value(style));
      else if (roll < 92) send_command(CMD_FIND, pick_value(style));
      else if (roll < 97) send_command(CMD_SPARE, pick_value(0));
      else                send_command(CMD_CLEAR, pick_value(0));
   endtask

   // Corner values, every command, tied extremes, a wrapping sum, misses,
   // the spare code and clears on a non-empty and on an empty store.
   task automatic test_directed_corners();
      send_command(CMD_FIND,   32'sd0);
      send_command(CMD_SPARE,  32'sh7FFF_FFFF);
      send_command(CMD_INSERT, 32'sd0);
      send_command(CMD_INSERT, 32'sh7FFF_FFFF);
      send_command(CMD_INSERT, 32'sh8000_0000);
      send_command(CMD_INSERT, -32'sd1);
      send_command(CMD_INSERT, 32'sh7FFF_FFFF);
      send_command(CMD_INSERT, 32'sh8000_0000);
      send_command(CMD_FIND,   32'sh8000_0000);
      send_command(CMD_FIND,   32'sd0);
      send_command(CMD_FIND,   32'sh7FFF_FFFF);
      send_command(CMD_FIND,   -32'sd1);
      send_command(CMD_FIND,   32'sh1234_5678);
      send_command(CMD_SPARE,  32'shAAAA_5555);
      send_command(CMD_CLEAR,  32'sh5555_AAAA);
      send_command(CMD_FIND,   32'sd0);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_FIND,   32'sd5);
      send_command(CMD_CLEAR,  32'sd0);
      send_command(CMD_CLEAR,  -32'sd1);
      wait_results_drained();
   endtask

   // Fills the store to the brim, checks that further inserts are refused,
   // then finds entries deep in the store before clearing it.
   task automatic test_full_store();
      int k;
      send_command(CMD_CLEAR, pick_value(0));
      while (shadow_count < DEPTH) send_command(CMD_INSERT, pick_value(0));
      for (k = 0; k < 3; k++) send_command(CMD_INSERT, pick_value(0));
      send_command(CMD_FIND, shadow_store[DEPTH-1]);
      send_command(CMD_FIND, shadow_store[DEPTH/2]);
      send_command(CMD_FIND, pick_value(0));
      send_command(CMD_SPARE, pick_value(0));
      send_command(CMD_CLEAR, pick_value(0));
      wait_results_drained();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the single command slot stays busy and req_tready drops.
   task automatic test_result_hold_off();
      int k;
      long_hold_cycles = 400;
      for (k = 0; k < 10; k++) mixed_step(1);
      wait_results_drained();
   endtask

   // The bulk of the run: build-up sequences, fill-to-full sequences and
   // bursts of arbitrary noise, with the odd pause until all results are in.
   task automatic test_random_traffic();
      int start, kind, style, n, k;
      start = beats_accepted - spares_done;
      while (beats_accepted - spares_done - start < RANDOM_ITEMS) begin
         kind  = $urandom_range(0, 9);
         style = $urandom_range(0, 2);
         if (kind < 6) begin
            n = $urandom_range(1, 40);
            for (k = 0; k < n; k++) mixed_step(style);
         end else if (kind < 8) begin
            while (shadow_count < DEPTH) begin
               if ($urandom_range(0, 3) == 0) mixed_step(style);
               else send_command(CMD_INSERT, pick_value(style));
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) send_command(CMD_INSERT, pick_value(style));
            n = $urandom_range(2, 6);
            for (k = 0; k < n; k++) send_command(CMD_FIND, pick_held_value(style));
         end else begin
            n = $urandom_range(5, 20);
            for (k = 0; k < n; k++)
               send_command(CMD_W'($urandom_range(0, 3)), data_type'($urandom));
         end
         if ($urandom_range(0, 3) == 0) send_command(CMD_CLEAR, pick_value(0));
         if ($urandom_range(0, 14) == 0) wait_results_drained();
      end
      wait_results_drained();
   endtask

   // Receiver: stretches of always ready, mostly ready, mostly stalled and
   // alternating, with a long hold-off whenever one is asked for.
   initial begin : result_receiver
      int mode;
      int stretch;
      @(posedge clock);
      forever begin
         if (long_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
            hold_offs_done++;
         end else begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 3) != 0);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ~rsp_tready;
               endcase
               @(posedge clock);
               if (long_hold_cycles > 0) break;
            end
         end
      end
   end

   // Reports one field that differs; the print budget keeps a badly broken
   // unit from flooding the log, but every mismatch is still counted.
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (print_left > 0) begin
            print_left--;
            $display("%0d ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
         end
      end
   endfunction

   // Every result beat taken by the receiver is compared with the oldest
   // prediction, field by field.
   always @(posedge clock) begin : result_checker
      stats_beat_type want;
      stats_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stats.size() == 0) begin
            error_count++;
            if (print_left > 0) begin
               print_left--;
               $display("%0d ns: result beat with nothing expected, actual %0h",
                        $time, rsp_tdata);
            end
         end else begin
            want = pending_stats.pop_front();
            got  = stats_beat_type'(rsp_tdata[123:0]);
            check_field("found",          32'(want.found),          32'(got.found));
            check_field("found_position", 32'(want.found_position), 32'(got.found_position));
            check_field("entry_count",    32'(want.entry_count),    32'(got.entry_count));
            check_field("total",          want.total,               got.total);
            check_field("max_value",      want.max_value,           got.max_value);
            check_field("max_position",   32'(want.max_position),   32'(got.max_position));
            check_field("min_value",      want.min_value,           got.min_value);
            check_field("min_position",   32'(want.min_position),   32'(got.min_position));
            check_field("empty_flag",     32'(want.empty_flag),     32'(got.empty_flag));
            check_field("insert_refused", 32'(want.insert_refused), 32'(got.insert_refused));
            check_field("padding",        32'd0,                    32'(rsp_tdata[127:124]));
         end
      end
   end

   // Main sequence: reset once, run each test in turn, then settle and judge.
   initial begin
      empty_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = pick_burst();
      test_directed_corners();
      test_full_store();
      test_result_hold_off();
      test_random_traffic();
      wait_results_drained();
      // The wait outlasts the longest find, so any stray beat shows by now.
      repeat (DEPTH + 10) @(posedge clock);
      if (pending_stats.size() != 0) begin
         error_count++;
         $display("%0d ns: %0d expected result beats never arrived",
                  $time, pending_stats.size());
      end
      $display("Covered %0d command beats: %0d inserts (%0d refused), %0d finds hit, %0d missed,",
               beats_accepted, inserts_done, inserts_refused, finds_hit, finds_missed);
      $display("%0d clears, %0d spare codes, store full %0d times, %0d long result hold-offs.",
               clears_done, spares_done, full_store_seen, hold_offs_done);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("Timeout with %0d result beats outstanding", pending_stats.size());
      $display("Verification failed");
      $finish;
   end

endmodule
